/* hdl/ltsp_pkg.sv */
`default_nettype none

package ltsp_pkg;

  // field and register widths
  localparam int unsigned LOAD_W      = 16;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned THRESH_W    = 16;
  localparam int unsigned LEVEL_W     = 17;
  localparam int unsigned AVG_W       = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned CODE_W      = 2;

  localparam int unsigned WINDOW_DEPTH_DEFAULT = 16;

  // weight of 0.3 in Q1.16 and 1.0 in Q1.16
  localparam logic [WEIGHT_W-1:0] WEIGHT_DEFAULT = 17'd19661;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 17'd65536;

  // register reset values
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd128;
  localparam logic [LEVEL_W-1:0]  UP_RESET     = 17'd20480;
  localparam logic [LEVEL_W-1:0]  DOWN_RESET   = 17'd7680;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_EMA_WEIGHT      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TREND_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_UP        = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_DOWN      = 2'd3;

  // trend codes
  localparam logic [CODE_W-1:0] TREND_FLAT = 2'd0;
  localparam logic [CODE_W-1:0] TREND_UP   = 2'd1;
  localparam logic [CODE_W-1:0] TREND_DOWN = 2'd2;

  // advice codes
  localparam logic [CODE_W-1:0] ADVICE_NONE = 2'd0;
  localparam logic [CODE_W-1:0] ADVICE_UP   = 2'd1;
  localparam logic [CODE_W-1:0] ADVICE_DOWN = 2'd2;

  // settings as seen by the datapath
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0] weight_comp;
    logic [THRESH_W-1:0] threshold;
    logic [LEVEL_W-1:0]  up_level;
    logic [LEVEL_W-1:0]  down_level;
  } cfg_t;

  // sequencer states, one product issued in each busy state
  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_OLD  = 10'b0000000010,
    ST_XSQ  = 10'b0000000100,
    ST_WX   = 10'b0000001000,
    ST_WP   = 10'b0000010000,
    ST_NX   = 10'b0000100000,
    ST_NQ   = 10'b0001000000,
    ST_SS   = 10'b0010000000,
    ST_EE   = 10'b0100000000,
    ST_FIN  = 10'b1000000000
  } state_t;

endpackage

`default_nettype wire

/* hdl/load_trend_spike_predictor.sv */
`default_nettype none

// the result is registered as the sequencer leaves ST_FIN; a new item is
// accepted only in idle, so not before the last result is registered; the
// shared multiplier forms eight products per item, one each cycle
// reset: clears the sums, the average, the fill count and the ring pointer;
// the sample memory is not cleared, entries are used only once written

module load_trend_spike_predictor #(
  parameter int unsigned WINDOW_DEPTH = ltsp_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [ltsp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [ltsp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [ltsp_pkg::LOAD_W-1:0]           observed_load,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic      [ltsp_pkg::LOAD_W-1:0]           smoothed_load,
  output logic signed [ltsp_pkg::LOAD_W:0]           load_change,
  output logic      [ltsp_pkg::LEVEL_W-1:0]          projected_load,
  output logic      [ltsp_pkg::CODE_W-1:0]           trend_code,
  output logic                                       spike_flag,
  output logic      [ltsp_pkg::CODE_W-1:0]           advice_code,
  output logic      [$clog2(WINDOW_DEPTH+1)-1:0]     fill_count
);

  import ltsp_pkg::*;

  localparam int unsigned LOG_D  = $clog2(WINDOW_DEPTH);
  localparam int unsigned SLOT_W = LOG_D;
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW     = LOAD_W + LOG_D;
  localparam int unsigned QW     = 2 * LOAD_W + LOG_D;
  localparam int unsigned A_W    = (SW > WEIGHT_W) ? SW : WEIGHT_W;
  localparam int unsigned B_W    = (QW > AVG_W) ? QW : AVG_W;
  localparam int unsigned PW     = A_W + B_W;
  localparam int unsigned VW     = 2 * SW;
  localparam int unsigned WX_W   = WEIGHT_W + LOAD_W;
  localparam int unsigned WP_W   = WEIGHT_W + AVG_W;
  localparam int unsigned ACC_W  = WP_W + 1;
  localparam int unsigned DW     = AVG_W + 1;

  cfg_t                 cfg;
  state_t               state;
  logic [LOAD_W-1:0]    x_reg;
  logic [SLOT_W-1:0]    write_slot;
  logic [CNT_W-1:0]     held_count;
  logic                 was_full;
  logic [SW-1:0]        running_sum;
  logic [QW-1:0]        running_square_sum;
  logic [AVG_W-1:0]     average_value;
  logic [AVG_W-1:0]     prev_avg;
  logic [WX_W-1:0]      wx_reg;
  logic                 e_pos;
  logic [SW-1:0]        e_reg;
  logic [VW-1:0]        nq_reg;
  logic [VW-1:0]        var_reg;
  logic signed [DW-1:0] diff_q;
  logic [DW-1:0]        pred_q;
  logic [CODE_W-1:0]    trend_q;

  logic [LOAD_W-1:0]    old_sample;
  logic [A_W-1:0]       mul_a;
  logic [B_W-1:0]       mul_b;
  logic [PW-1:0]        prod;
  logic                 in_take;
  logic                 out_free;
  logic                 ring_full;
  logic [ACC_W-1:0]     ema_sum;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] thr;
  logic signed [DW:0]   pred_s;
  logic                 spike;
  logic [CODE_W-1:0]    advice;

  assign in_ready  = (state == ST_IDLE) && !rst;
  assign in_take   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign ring_full = (held_count == CNT_W'(WINDOW_DEPTH));

  // configuration registers
  ltsp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sample ring: oldest entry read on accept, new sample written in the next cycle
  ltsp_ram #(
    .WIDTH (LOAD_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_OLD),
    .waddr (write_slot),
    .wdata (x_reg),
    .re    (in_take),
    .raddr (write_slot),
    .rdata (old_sample)
  );

  // operand selection for the shared multiplier
  always_comb begin
    unique case (state)
      ST_OLD: begin
        mul_a = A_W'(old_sample);
        mul_b = B_W'(old_sample);
      end
      ST_XSQ: begin
        mul_a = A_W'(x_reg);
        mul_b = B_W'(x_reg);
      end
      ST_WX: begin
        mul_a = A_W'(cfg.weight);
        mul_b = B_W'(x_reg);
      end
      ST_WP: begin
        mul_a = A_W'(cfg.weight_comp);
        mul_b = B_W'(average_value);
      end
      ST_NX: begin
        mul_a = A_W'(held_count);
        mul_b = B_W'(x_reg);
      end
      ST_NQ: begin
        mul_a = A_W'(held_count);
        mul_b = B_W'(running_square_sum);
      end
      ST_SS: begin
        mul_a = A_W'(running_sum);
        mul_b = B_W'(running_sum);
      end
      ST_EE, ST_FIN: begin
        mul_a = A_W'(e_reg);
        mul_b = B_W'(e_reg);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ltsp_mul #(
    .A_W (A_W),
    .B_W (B_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // ema blend: weight times sample in Q17.32 plus complement times previous
  assign ema_sum = {1'b0, wx_reg, {FRAC_W{1'b0}}} + ACC_W'(prod[WP_W-1:0]);

  // change, trend threshold and prediction sum in Q17.16
  always_comb begin
    diff   = $signed({1'b0, average_value}) - $signed({1'b0, prev_avg});
    thr    = $signed({1'b0, cfg.threshold, {FRAC_W{1'b0}}});
    pred_s = $signed({1'b0, average_value}) + (DW+1)'(diff);
  end

  // spike test and advice
  always_comb begin
    spike = e_pos && (prod > PW'({var_reg, 2'b00}));
    if (pred_q > DW'({cfg.up_level, {FRAC_W{1'b0}}}) || spike) begin
      advice = ADVICE_UP;
    end else if (pred_q < DW'({cfg.down_level, {FRAC_W{1'b0}}}) &&
                 trend_q == TREND_DOWN) begin
      advice = ADVICE_DOWN;
    end else begin
      advice = ADVICE_NONE;
    end
  end

  // sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      write_slot         <= '0;
      held_count         <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      average_value      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_OLD;
          end
        end
        ST_OLD: begin
          running_sum <= running_sum + SW'(x_reg) -
                         (ring_full ? SW'(old_sample) : SW'(0));
          if (!ring_full) begin
            held_count <= held_count + CNT_W'(1);
          end
          if (write_slot == SLOT_W'(WINDOW_DEPTH - 1)) begin
            write_slot <= '0;
          end else begin
            write_slot <= write_slot + SLOT_W'(1);
          end
          state <= ST_XSQ;
        end
        ST_XSQ: begin
          if (was_full) begin
            running_square_sum <= running_square_sum - prod[QW-1:0];
          end
          state <= ST_WX;
        end
        ST_WX: begin
          running_square_sum <= running_square_sum + prod[QW-1:0];
          state <= ST_WP;
        end
        ST_WP: begin
          state <= ST_NX;
        end
        ST_NX: begin
          if (held_count == CNT_W'(1)) begin
            average_value <= {x_reg, {FRAC_W{1'b0}}};
          end else begin
            average_value <= ema_sum[FRAC_W +: AVG_W];
          end
          state <= ST_NQ;
        end
        ST_NQ: state <= ST_SS;
        ST_SS: state <= ST_EE;
        ST_EE: state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_reg <= observed_load;
    end
    unique case (state)
      ST_OLD: was_full <= ring_full;
      ST_WP:  wx_reg   <= prod[WX_W-1:0];
      ST_NX:  prev_avg <= average_value;
      ST_NQ: begin
        e_pos  <= prod > PW'(running_sum);
        e_reg  <= prod[SW-1:0] - running_sum;
        diff_q <= diff;
        pred_q <= pred_s[DW] ? '0 : pred_s[DW-1:0];
        if (diff > thr) begin
          trend_q <= TREND_UP;
        end else if (diff < -thr) begin
          trend_q <= TREND_DOWN;
        end else begin
          trend_q <= TREND_FLAT;
        end
      end
      ST_SS:  nq_reg  <= prod[VW-1:0];
      ST_EE:  var_reg <= nq_reg - prod[VW-1:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      smoothed_load  <= average_value[AVG_W-1:FRAC_W];
      load_change    <= diff_q[DW-1:FRAC_W];
      projected_load <= pred_q[DW-1:FRAC_W];
      trend_code     <= trend_q;
      spike_flag     <= spike;
      advice_code    <= advice;
      fill_count     <= held_count;
    end
  end

endmodule

`default_nettype wire

/* hdl/ltsp_ram.sv */
`default_nettype none

module ltsp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/ltsp_mul.sv */
`default_nettype none

module ltsp_mul #(
  parameter int unsigned A_W = 20,
  parameter int unsigned B_W = 36
) (
  input  wire logic               clk,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic      [A_W+B_W-1:0] p
);

  // shared unsigned multiplier, product registered
  always_ff @(posedge clk) begin
    p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

`default_nettype wire

/* hdl/ltsp_cfg.sv */
`default_nettype none

module ltsp_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [ltsp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ltsp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ltsp_pkg::cfg_t                          cfg
);

  import ltsp_pkg::*;

  logic [WEIGHT_W-1:0] weight_eff;

  // out-of-range weight falls back to 0.3
  always_comb begin
    if (cfg_data == '0 || cfg_data > WEIGHT_ONE) begin
      weight_eff = WEIGHT_DEFAULT;
    end else begin
      weight_eff = cfg_data;
    end
  end

  // register writes, weight stored already cleaned with its complement
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight      <= WEIGHT_DEFAULT;
      cfg.weight_comp <= WEIGHT_ONE - WEIGHT_DEFAULT;
      cfg.threshold   <= THRESH_RESET;
      cfg.up_level    <= UP_RESET;
      cfg.down_level  <= DOWN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EMA_WEIGHT: begin
          cfg.weight      <= weight_eff;
          cfg.weight_comp <= WEIGHT_ONE - weight_eff;
        end
        REG_TREND_THRESHOLD: cfg.threshold  <= cfg_data[THRESH_W-1:0];
        REG_SCALE_UP:        cfg.up_level   <= cfg_data[LEVEL_W-1:0];
        REG_SCALE_DOWN:      cfg.down_level <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
